// ===== hdl/ptc_pkg.sv =====
// Shared types and constants for the PMBus telemetry converter.
// Depends on nothing; used by every module of the converter.
`timescale 1ns / 1ps

package ptc_pkg;

	// Scale factors: mV and mA use x1000, centidegrees use x100
	localparam logic [9:0] VOUT_SCALE = 10'd1000;
	localparam logic [9:0] IOUT_SCALE = 10'd1000;
	localparam logic [6:0] TEMP_SCALE = 7'd100;

	// Power rounding and saturation: mw = (mv * ma + 500) / 1000
	localparam logic [47:0] PWR_BIAS  = 48'd500;
	localparam logic [47:0] PWR_LIMIT = 48'd4294967296000;  // 1000 * 2^32

	// Reciprocal of 125 for a 39-bit dividend, scaled by 2^46
	localparam int          PWR_SHIFT = 46;
	localparam logic [39:0] PWR_RECIP = 40'(((64'd1 << 46) + 64'd124) / 64'd125);

	// Saturation values
	localparam logic [15:0]        MV_MAX = 16'hFFFF;
	localparam logic [30:0]        MA_MAX = 31'h7FFF_FFFF;
	localparam logic [31:0]        MW_MAX = 32'hFFFF_FFFF;
	localparam logic signed [15:0] TC_MAX = 16'sh7FFF;
	localparam logic signed [15:0] TC_MIN = 16'sh8000;

	// One raw telemetry set
	typedef struct packed {
		logic [7:0]  operation_byte;
		logic [7:0]  vmode_byte;
		logic [15:0] vout_word;
		logic [15:0] iout_word;
		logic [15:0] temp_word;
		logic [15:0] status_in;
	} ptc_in_t;

	// One set of engineering values
	typedef struct packed {
		logic [15:0]        vout_millivolts;
		logic [30:0]        iout_milliamps;
		logic [31:0]        power_milliwatts;
		logic signed [15:0] temp_centidegrees;
		logic [15:0]        status_out;
		logic               output_enabled;
	} ptc_out_t;

	// Decoded and clamped values handed from decode to power stages
	typedef struct packed {
		logic [15:0]        mv;
		logic [30:0]        ma;
		logic signed [15:0] tc;
		logic [15:0]        status;
		logic               en;
	} ptc_dec_t;

endpackage

// ===== hdl/ptc_linear_decode.sv =====
// LINEAR16 / LINEAR11 decode: scale multiply, then rounding shift and clamp.
// Two pipeline stages; depends on ptc_pkg.
`timescale 1ns / 1ps

module ptc_linear_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  ptc_pkg::ptc_in_t up_data,
	output logic             dn_valid,
	input  logic             dn_ready,
	output ptc_pkg::ptc_dec_t dn_data
);

	// Stage 1 registers: scaled magnitudes and exponents
	logic        valid_s1;
	logic [25:0] vprod_s1;
	logic [4:0]  vexp_s1;
	logic [19:0] iprod_s1;
	logic [4:0]  iexp_s1;
	logic        ineg_s1;
	logic [16:0] tprod_s1;
	logic [4:0]  texp_s1;
	logic        tneg_s1;
	logic [15:0] status_s1;
	logic        en_s1;

	// Stage 2 registers: clamped results
	logic              valid_s2;
	ptc_pkg::ptc_dec_t dec_s2;

	logic ready_s1;
	logic ready_s2;

	// Per-stage flow control: a stage takes a beat when empty or draining
	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	// Stage 1: split LINEAR11 words, take magnitudes, multiply by scale
	logic        ineg_c, tneg_c;
	logic [11:0] imag_c, tmag_c;
	logic [20:0] iprod_c;
	logic [17:0] tprod_c;
	logic [25:0] vprod_c;

	always_comb begin
		ineg_c  = up_data.iout_word[10];
		tneg_c  = up_data.temp_word[10];
		imag_c  = ineg_c ? (12'h800 - {1'b0, up_data.iout_word[10:0]})
		                 : {1'b0, up_data.iout_word[10:0]};
		tmag_c  = tneg_c ? (12'h800 - {1'b0, up_data.temp_word[10:0]})
		                 : {1'b0, up_data.temp_word[10:0]};
		vprod_c = up_data.vout_word * ptc_pkg::VOUT_SCALE;
		iprod_c = imag_c[10:0] * ptc_pkg::IOUT_SCALE;
		tprod_c = tmag_c[10:0] * ptc_pkg::TEMP_SCALE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			vprod_s1  <= vprod_c;
			vexp_s1   <= up_data.vmode_byte[4:0];
			iprod_s1  <= iprod_c[19:0];
			iexp_s1   <= up_data.iout_word[15:11];
			ineg_s1   <= ineg_c;
			tprod_s1  <= tprod_c[16:0];
			texp_s1   <= up_data.temp_word[15:11];
			tneg_s1   <= tneg_c;
			status_s1 <= up_data.status_in;
			en_s1     <= up_data.operation_byte[7];
		end
	end

	// Stage 2: apply exponent (rounding right shift or left shift), clamp
	logic [4:0]  vsh, ish, tsh;
	logic [26:0] vrnd;
	logic [41:0] vlft;
	logic        vsat;
	logic [20:0] irnd;
	logic [34:0] ilft, imag;
	logic [17:0] trnd;
	logic [31:0] tlft, tmag;
	ptc_pkg::ptc_dec_t dec_c;

	always_comb begin
		// right shift amounts for negative exponents, 1..16
		vsh = 5'(6'd32 - {1'b0, vexp_s1});
		ish = 5'(6'd32 - {1'b0, iexp_s1});
		tsh = 5'(6'd32 - {1'b0, texp_s1});

		// voltage: half of the divisor is added before the shift
		vrnd = (27'(vprod_s1) + (27'd1 << (vsh - 5'd1))) >> vsh;
		vlft = 42'(vprod_s1) << vexp_s1[3:0];
		vsat = vexp_s1[4] ? (|vrnd[26:16]) : (|vlft[41:16]);

		// current magnitude, rounded half up
		irnd = (21'(iprod_s1) + (21'd1 << (ish - 5'd1))) >> ish;
		ilft = 35'(iprod_s1) << iexp_s1[3:0];
		imag = iexp_s1[4] ? 35'(irnd) : ilft;

		// temperature magnitude, rounded half up
		trnd = (18'(tprod_s1) + (18'd1 << (tsh - 5'd1))) >> tsh;
		tlft = 32'(tprod_s1) << texp_s1[3:0];
		tmag = texp_s1[4] ? 32'(trnd) : tlft;

		dec_c.mv = vsat ? ptc_pkg::MV_MAX : (vexp_s1[4] ? vrnd[15:0] : vlft[15:0]);

		// negative current clamps to zero
		if (ineg_s1) begin
			dec_c.ma = '0;
		end else if (|imag[34:31]) begin
			dec_c.ma = ptc_pkg::MA_MAX;
		end else begin
			dec_c.ma = imag[30:0];
		end

		// reapply sign, clamp to int16
		if (tneg_s1) begin
			if (tmag > 32'd32768) begin
				dec_c.tc = ptc_pkg::TC_MIN;
			end else begin
				dec_c.tc = 16'(~tmag[15:0] + 16'd1);
			end
		end else if (tmag > 32'd32767) begin
			dec_c.tc = ptc_pkg::TC_MAX;
		end else begin
			dec_c.tc = tmag[15:0];
		end

		dec_c.status = status_s1;
		dec_c.en     = en_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			dec_s2 <= dec_c;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = dec_s2;

endmodule

// ===== hdl/ptc_power_calc.sv =====
// Power in mW: voltage times current, rounded divide by 1000, saturate.
// Three pipeline stages, reciprocal multiply in partial products; depends on ptc_pkg.
`timescale 1ns / 1ps

module ptc_power_calc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  ptc_pkg::ptc_dec_t up_data,
	output logic              dn_valid,
	input  logic              dn_ready,
	output ptc_pkg::ptc_out_t dn_data
);

	logic              valid_s3, valid_s4, valid_s5;
	logic              ready_s3, ready_s4, ready_s5;
	ptc_pkg::ptc_dec_t dec_s3, dec_s4;
	logic [46:0]       prod_s3;
	logic              sat_s4;
	logic [39:0]       pp_ll_s4, pp_lh_s4;
	logic [38:0]       pp_hl_s4, pp_hh_s4;
	ptc_pkg::ptc_out_t res_s5;

	// Per-stage flow control
	assign ready_s5 = !valid_s5 || dn_ready;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign up_ready = ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= up_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Stage 3: 16 x 31 product
	always_ff @(posedge clk) begin
		if (ready_s3 && up_valid) begin
			dec_s3  <= up_data;
			prod_s3 <= up_data.mv * up_data.ma;
		end
	end

	// Stage 4: add rounding bias, saturation check, partial products of
	// (z / 8) * recip(125)
	logic [47:0] z_c;
	logic [38:0] y_c;

	always_comb begin
		z_c = {1'b0, prod_s3} + ptc_pkg::PWR_BIAS;
		y_c = z_c[41:3];
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			dec_s4   <= dec_s3;
			sat_s4   <= (z_c >= ptc_pkg::PWR_LIMIT);
			pp_ll_s4 <= y_c[19:0]  * ptc_pkg::PWR_RECIP[19:0];
			pp_lh_s4 <= y_c[19:0]  * ptc_pkg::PWR_RECIP[39:20];
			pp_hl_s4 <= y_c[38:20] * ptc_pkg::PWR_RECIP[19:0];
			pp_hh_s4 <= y_c[38:20] * ptc_pkg::PWR_RECIP[39:20];
		end
	end

	// Stage 5: sum partial products, take quotient, assemble result
	logic [78:0] sum_c;
	logic [31:0] mw_c;

	always_comb begin
		sum_c = (79'(pp_hh_s4) << 40)
		      + ((79'(pp_lh_s4) + 79'(pp_hl_s4)) << 20)
		      + 79'(pp_ll_s4);
		mw_c  = sat_s4 ? ptc_pkg::MW_MAX
		               : sum_c[ptc_pkg::PWR_SHIFT +: 32];
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && valid_s4) begin
			res_s5.vout_millivolts   <= dec_s4.mv;
			res_s5.iout_milliamps    <= dec_s4.ma;
			res_s5.power_milliwatts  <= mw_c;
			res_s5.temp_centidegrees <= dec_s4.tc;
			res_s5.status_out        <= dec_s4.status;
			res_s5.output_enabled    <= dec_s4.en;
		end
	end

	assign dn_valid = valid_s5;
	assign dn_data  = res_s5;

endmodule

// ===== hdl/pmbus_telemetry_converter_core.sv =====
// PMBus telemetry converter: raw LINEAR16/LINEAR11 set in, engineering values out.
// Top level; depends on ptc_pkg, ptc_linear_decode and ptc_power_calc.
//
// One telemetry set is accepted per cycle unless a stalled output has filled
// every stage. Two stages decode and clamp voltage, current and temperature,
// three stages form power (product, reciprocal partial products for the
// divide by 1000, final sum). Each stage holds its own valid bit and takes a
// new beat whenever it is empty or its successor takes its beat, so a stalled
// output holds up to five sets without loss and bubbles close up behind it.
// Reset only clears the valid bits; there is no other state.
`timescale 1ns / 1ps

module pmbus_telemetry_converter_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              raw_valid,
	output logic              raw_ready,
	input  ptc_pkg::ptc_in_t  raw,
	output logic              eng_valid,
	input  logic              eng_ready,
	output ptc_pkg::ptc_out_t eng
);

	logic              dec_valid;
	logic              dec_ready;
	ptc_pkg::ptc_dec_t dec_data;

	// Decode and clamp the three readings
	ptc_linear_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (raw_valid),
		.up_ready (raw_ready),
		.up_data  (raw),
		.dn_valid (dec_valid),
		.dn_ready (dec_ready),
		.dn_data  (dec_data)
	);

	// Power and result assembly
	ptc_power_calc u_power (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (dec_valid),
		.up_ready (dec_ready),
		.up_data  (dec_data),
		.dn_valid (eng_valid),
		.dn_ready (eng_ready),
		.dn_data  (eng)
	);

endmodule

// ===== tb/pmbus_telemetry_converter_core_tb.sv =====
// Self-checking testbench for pmbus_telemetry_converter_core.
// Depends on ptc_pkg and the converter RTL. A scoreboard predicts every telemetry
// set it sees accepted and checks each result beat against it in order.
`timescale 1ns / 1ps

module pmbus_telemetry_converter_core_tb;

	localparam int unsigned MILLI_SCALE = 1000;
	localparam int unsigned CENTI_SCALE = 100;
	localparam int unsigned SETS_PER_PHASE = 350;

	// Predicts converter output and checks result beats in arrival order
	class telemetry_scoreboard;
		ptc_pkg::ptc_out_t pending_eng[$];
		int unsigned mismatch_count;
		int unsigned checked_count;

		// LINEAR11: 11-bit signed mantissa, 5-bit signed exponent, rounds half away from zero
		function longint decode_linear11(logic [15:0] word, int unsigned scale);
			logic [10:0] man;
			logic [4:0] ex;
			longint unsigned mag;
			longint unsigned prod;
			int unsigned sh;
			man = word[10:0];
			ex = word[15:11];
			mag = man[10] ? (64'd2048 - 64'(man)) : 64'(man);
			prod = mag * scale;
			if (ex[4]) begin
				sh = 32 - ex;
				prod = (prod + ((64'd1 << sh) >> 1)) >> sh;
			end else begin
				prod = prod << ex;
			end
			return man[10] ? -longint'(prod) : longint'(prod);
		endfunction

		// LINEAR16: unsigned mantissa, exponent in the low five bits of the mode byte
		function longint unsigned decode_linear16(logic [15:0] raw_v, logic [7:0] mode);
			logic [4:0] ex;
			longint unsigned prod;
			int unsigned sh;
			ex = mode[4:0];
			prod = 64'(raw_v) * MILLI_SCALE;
			if (ex[4]) begin
				sh = 32 - ex;
				return (prod + ((64'd1 << sh) >> 1)) >> sh;
			end
			return prod << ex;
		endfunction

		function ptc_pkg::ptc_out_t predict_eng(ptc_pkg::ptc_in_t s);
			ptc_pkg::ptc_out_t r;
			longint unsigned mv;
			longint ma_s;
			longint unsigned ma;
			longint unsigned mw;
			longint tc;
			mv = decode_linear16(s.vout_word, s.vmode_byte);
			ma_s = decode_linear11(s.iout_word, MILLI_SCALE);
			tc = decode_linear11(s.temp_word, CENTI_SCALE);
			if (mv > 64'd65535) mv = 64'd65535;
			if (ma_s < 0) ma = 0;
			else if (ma_s > 64'sh7FFF_FFFF) ma = 64'h7FFF_FFFF;
			else ma = longint'(ma_s);
			mw = (mv * ma + 64'd500) / 64'd1000;
			if (mw > 64'hFFFF_FFFF) mw = 64'hFFFF_FFFF;
			if (tc > 32767) tc = 32767;
			if (tc < -32768) tc = -32768;
			r.vout_millivolts = mv[15:0];
			r.iout_milliamps = ma[30:0];
			r.power_milliwatts = mw[31:0];
			r.temp_centidegrees = 16'(tc);
			r.status_out = s.status_in;
			r.output_enabled = s.operation_byte[7];
			return r;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatch_count++;
		endtask

		task check_field(string name, longint got, longint want);
			if (got != want)
				report($sformatf("beat %0d %s got 0x%0h expected 0x%0h",
					checked_count, name, got, want));
		endtask

		function void note_raw_set(ptc_pkg::ptc_in_t s);
			pending_eng.push_back(predict_eng(s));
		endfunction

		task check_eng_set(ptc_pkg::ptc_out_t got);
			ptc_pkg::ptc_out_t want;
			if (pending_eng.size() == 0) begin
				report($sformatf("unexpected result beat 0x%0h", got));
			end else begin
				want = pending_eng.pop_front();
				check_field("vout_millivolts", got.vout_millivolts, want.vout_millivolts);
				check_field("iout_milliamps", got.iout_milliamps, want.iout_milliamps);
				check_field("power_milliwatts", got.power_milliwatts, want.power_milliwatts);
				check_field("temp_centidegrees", got.temp_centidegrees,
					want.temp_centidegrees);
				check_field("status_out", got.status_out, want.status_out);
				check_field("output_enabled", got.output_enabled, want.output_enabled);
			end
			checked_count++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic raw_valid;
	logic raw_ready;
	ptc_pkg::ptc_in_t raw;
	logic eng_valid;
	logic eng_ready;
	ptc_pkg::ptc_out_t eng;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	telemetry_scoreboard sb = new;

	pmbus_telemetry_converter_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.raw_valid(raw_valid),
		.raw_ready(raw_ready),
		.raw(raw),
		.eng_valid(eng_valid),
		.eng_ready(eng_ready),
		.eng(eng)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: ready toggles at random on the falling edge
	always @(negedge clk) begin
		if (arst_n)
			eng_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Both handshakes sampled at the rising edge; results checked before new sets are noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (eng_valid && eng_ready)
				sb.check_eng_set(eng);
			if (raw_valid && raw_ready)
				sb.note_raw_set(raw);
		end
	end

	function ptc_pkg::ptc_in_t make_set(logic [7:0] op, logic [7:0] mode, logic [15:0] v,
		logic [15:0] i, logic [15:0] t, logic [15:0] st);
		ptc_pkg::ptc_in_t s;
		s.operation_byte = op;
		s.vmode_byte = mode;
		s.vout_word = v;
		s.iout_word = i;
		s.temp_word = t;
		s.status_in = st;
		return s;
	endfunction

	// Half of the LINEAR11 words are raw noise, the rest use moderate exponents
	function logic [15:0] rand_linear11();
		logic [4:0] ex;
		if ($urandom_range(1) == 0)
			return 16'($urandom);
		ex = 5'($urandom_range(20, 35));	// -12..3
		return {ex, 11'($urandom)};
	endfunction

	function ptc_pkg::ptc_in_t rand_set();
		ptc_pkg::ptc_in_t s;
		s.operation_byte = 8'($urandom);
		if ($urandom_range(1) == 0)
			s.vmode_byte = 8'($urandom);
		else
			s.vmode_byte = {3'($urandom), 5'($urandom_range(20, 34))};	// -12..2
		s.vout_word = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 99)) : 16'($urandom);
		s.iout_word = rand_linear11();
		s.temp_word = rand_linear11();
		s.status_in = 16'($urandom);
		return s;
	endfunction

	// Drive one set, starting and ending at a falling edge
	task send_set(input ptc_pkg::ptc_in_t s);
		if ($urandom_range(99) < send_idle_pct) begin
			raw_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		raw <= s;
		raw_valid <= 1'b1;
		@(posedge clk);
		while (!raw_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task send_directed();
		// zeros and ones
		send_set(make_set(8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_set(make_set(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		// largest voltage exponent saturates; one amp
		send_set(make_set(8'h80, 8'h0F, 16'hFFFF, 16'h0001, 16'h0000, 16'hA5A5));
		// most negative exponents
		send_set(make_set(8'h7F, 8'h10, 16'hFFFF, 16'h83FF, 16'h8001, 16'h5A5A));
		// exact halves round up, unused mode bits set
		send_set(make_set(8'h80, 8'hFC, 16'h0001, 16'hE001, 16'hE801, 16'h0001));
		// negative halves round away from zero; current clamps to zero
		send_set(make_set(8'h80, 8'h1C, 16'h0003, 16'hE7FF, 16'hEFFF, 16'h8000));
		// current and temperature saturate high, power saturates
		send_set(make_set(8'h80, 8'h00, 16'hFFFF, 16'h7BFF, 16'h7BFF, 16'h7FFF));
		// most negative mantissa with largest exponent
		send_set(make_set(8'h00, 8'h00, 16'h0041, 16'h7C00, 16'h7C00, 16'hFFFE));
		// tiny voltage and current: power rounds half up
		send_set(make_set(8'h80, 8'h16, 16'h0001, 16'hF801, 16'hF064, 16'h1234));
		send_set(make_set(8'h80, 8'hE0, 16'd12, 16'hF064, 16'hF064, 16'h4321));
		send_set(make_set(8'h01, 8'h1F, 16'd3300, 16'hF803, 16'hF807, 16'h00FF));
		send_set(make_set(8'hC0, 8'h17, 16'd12288, 16'hD20A, 16'hE4C8, 16'hFF00));
		// voltage just below and just above the clamp limit
		send_set(make_set(8'h80, 8'h00, 16'd65, 16'h0001, 16'h03FF, 16'h0F0F));
		send_set(make_set(8'h80, 8'h01, 16'd33, 16'h0400, 16'h0400, 16'hF0F0));
		send_set(make_set(8'h40, 8'h1D, 16'h8000, 16'h07FF, 16'h07FF, 16'h0000));
		send_set(make_set(8'h80, 8'h05, 16'h0800, 16'h23E8, 16'hC3E8, 16'hCAFE));
	endtask

	task send_random(int unsigned count);
		repeat (count) send_set(rand_set());
	endtask

	initial begin
		arst_n = 1'b0;
		raw_valid = 1'b0;
		eng_ready = 1'b0;
		raw = '0;
		send_idle_pct = 30;
		recv_idle_pct = 47;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_directed();
		send_random(SETS_PER_PHASE);
		send_idle_pct = 47;
		recv_idle_pct = 30;
		send_random(SETS_PER_PHASE);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(SETS_PER_PHASE);
		raw_valid <= 1'b0;

		// drain, then allow for any stray beats from the five-stage pipe
		while (sb.pending_eng.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (sb.mismatch_count == 0)
			$display("pmbus_telemetry_converter_core_tb: PASS");
		else
			$display("pmbus_telemetry_converter_core_tb: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("timeout, %0d results outstanding", sb.pending_eng.size());
		$display("pmbus_telemetry_converter_core_tb: FAIL");
		$finish;
	end

endmodule
